/* hdl/sm3_pkg.sv */
// SM3 hash engine package: constants, shared types and the rotate and
// permutation helpers used by the round unit and the compression core.
// Depends on nothing.
package sm3_pkg;

    localparam logic [31:0] T_LOW   = 32'h79cc4519;
    localparam logic [31:0] T_HIGH  = 32'h7a879d8a;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam int BLOCK_BYTES = 64;
    localparam int POS_W       = $clog2(BLOCK_BYTES);
    localparam logic [POS_W-1:0] LEN_POS   = POS_W'(56);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(BLOCK_BYTES - 1);

    localparam int ROUNDS  = 64;
    localparam int ROUND_W = $clog2(ROUNDS);
    localparam logic [ROUND_W-1:0] LAST_ROUND  = ROUND_W'(ROUNDS - 1);
    localparam logic [ROUND_W-1:0] LAST_EARLY  = ROUND_W'(15);

    // The bit length is 64 bits wide, so 61 bits of byte count suffice.
    localparam int CNT_W = 61;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        logic [31:0] f;
        logic [31:0] g;
        logic [31:0] h;
    } sm3_words_t;

    localparam sm3_words_t SM3_IV = '{
        a: 32'h7380166F, b: 32'h4914B2B9, c: 32'h172442D7, d: 32'hDA8A0600,
        e: 32'hA96F30BC, f: 32'h163138AA, g: 32'hE38DEE4D, h: 32'hB0FB0E4E
    };

    typedef struct packed {
        logic start;
        logic iv_load;
    } sm3_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sm3_stat_t;

    // Rotate left; callers only use constant amounts between 1 and 31.
    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

endpackage

/* hdl/sm3_round.sv */
// SM3 round unit: one compression round on the eight working words.
// Depends on sm3_pkg.
module sm3_round (
    input  sm3_pkg::sm3_words_t cur,
    input  logic [31:0]         w,
    input  logic [31:0]         w4,
    input  logic [31:0]         t_rot,
    input  logic                early,
    output sm3_pkg::sm3_words_t nxt
);
    import sm3_pkg::*;

    logic [31:0] a12;
    logic [31:0] ss1;
    logic [31:0] ss2;
    logic [31:0] ff;
    logic [31:0] gg;
    logic [31:0] tt1;
    logic [31:0] tt2;

    always_comb
    begin
        a12 = rotl(cur.a, 12);
        ss1 = rotl(a12 + cur.e + t_rot, 7);
        ss2 = ss1 ^ a12;
        if (early)
        begin
            ff = cur.a ^ cur.b ^ cur.c;
            gg = cur.e ^ cur.f ^ cur.g;
        end
        else
        begin
            ff = (cur.a & cur.b) | (cur.a & cur.c) | (cur.b & cur.c);
            gg = (cur.e & cur.f) | (~cur.e & cur.g);
        end
        tt1 = ff + cur.d + ss2 + (w ^ w4);
        tt2 = gg + cur.h + ss1 + w;

        nxt.a = tt1;
        nxt.b = cur.a;
        nxt.c = rotl(cur.b, 9);
        nxt.d = cur.c;
        nxt.e = p0(tt2);
        nxt.f = cur.e;
        nxt.g = rotl(cur.f, 19);
        nxt.h = cur.g;
    end

endmodule

/* hdl/sm3_core.sv */
// SM3 compression core: a 16-word expansion window and the shared round
// unit run one round per clock, then fold into the chaining value.
// Depends on sm3_pkg and sm3_round.
module sm3_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sm3_pkg::sm3_ctrl_t  ctrl,
    input  logic [511:0]        block,
    output sm3_pkg::sm3_stat_t  stat,
    output sm3_pkg::sm3_words_t chain
);
    import sm3_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_ROUND = 3'b010,
        C_FOLD  = 3'b100
    } core_state_t;

    core_state_t          state_reg, state_next;
    logic [ROUND_W-1:0]   round_reg, round_next;
    sm3_words_t           chain_reg, chain_next;
    sm3_words_t           work_reg, work_next;
    logic [15:0][31:0]    win_reg, win_next;
    logic [31:0]          t_reg, t_next;
    sm3_words_t           round_out;
    logic [31:0]          exp_word;

    sm3_round u_round (
        .cur   (work_reg),
        .w     (win_reg[0]),
        .w4    (win_reg[4]),
        .t_rot (t_reg),
        .early (round_reg <= LAST_EARLY),
        .nxt   (round_out)
    );

    // Word j+16 of the expansion from the window that holds words j to j+15.
    assign exp_word = p1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 15))
                      ^ rotl(win_reg[3], 7) ^ win_reg[10];

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        chain_next = chain_reg;
        work_next  = work_reg;
        win_next   = win_reg;
        t_next     = t_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (ctrl.start)
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        win_next[i] = block[511 - 32 * i -: 32];
                    end
                    work_next  = chain_reg;
                    round_next = '0;
                    t_next     = T_LOW;
                    state_next = C_ROUND;
                end
                else if (ctrl.iv_load)
                begin
                    chain_next = SM3_IV;
                end
            end
            C_ROUND:
            begin
                work_next = round_out;
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = exp_word;
                // The round constant rotates by one each round; the second
                // constant enters already rotated by sixteen.
                t_next     = (round_reg == LAST_EARLY) ? rotl(T_HIGH, 16) : rotl(t_reg, 1);
                round_next = round_reg + 1'b1;
                if (round_reg == LAST_ROUND)
                begin
                    state_next = C_FOLD;
                end
            end
            C_FOLD:
            begin
                chain_next = sm3_words_t'(chain_reg ^ work_reg);
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            round_reg <= '0;
            chain_reg <= SM3_IV;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        win_reg  <= win_next;
        t_reg    <= t_next;
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_FOLD);
    assign chain     = chain_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> state_reg == C_IDLE)
        else $error("compression started while the core is busy");

    a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_ROUND && round_reg == LAST_ROUND) |=> state_reg == C_FOLD)
        else $error("fold did not follow the last round");

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |=> !stat.busy)
        else $error("core still busy after fold");
`endif

endmodule

/* hdl/sm3_hash_engine.sv */
// SM3 hash engine top level: byte packing, padding sequencer and digest
// output register around the compression core.
// Depends on sm3_pkg, sm3_round and sm3_core.
//
//  channel | dir | payload                         | accepted when
//  s_*     | in  | tdata=data_byte, tuser=has_byte | s_tvalid && s_tready
//          |     | tlast=last_byte                 |
//  m_*     | out | tdata=digest_0..digest_3        | m_tvalid && m_tready
//
// A plain byte is simply absorbed into the block buffer. The byte that fills a
// block adds a start state, the 64 rounds of the shared round unit and a fold
// state. A final item adds the pad bytes up to the length field, one or two
// compressions and a digest step.
// Reset loads the initial value and clears the byte count; no clearing pass.
// The digest waits in the output register; only a second digest that finds
// it still untaken holds the sequencer, and s_tready is low meanwhile.
module sm3_hash_engine (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tuser,   // [0] has_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // [63:0] digest_0, [127:64] digest_1,
                                    // [191:128] digest_2, [255:192] digest_3
);
    import sm3_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD80 = 7'b0000010,
        ST_PADZ  = 7'b0000100,
        ST_LEN   = 7'b0001000,
        ST_KICK  = 7'b0010000,
        ST_WAIT  = 7'b0100000,
        ST_FIN   = 7'b1000000
    } top_state_t;

    top_state_t         state_reg, state_next;
    top_state_t         ret_reg, ret_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [511:0]       buf_reg, buf_next;
    logic               out_valid_reg, out_valid_next;
    logic [255:0]       out_reg, out_next;
    sm3_ctrl_t          core_ctrl;
    sm3_stat_t          core_stat;
    sm3_words_t         chain;
    logic               accept;
    logic               slot_free;

    sm3_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .block (buf_reg),
        .stat  (core_stat),
        .chain (chain)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        buf_next       = buf_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_tready;
        core_ctrl      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser)
                    begin
                        buf_next   = {buf_reg[503:0], s_tdata};
                        pos_next   = pos_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        if (pos_reg == LAST_POS)
                        begin
                            ret_next   = s_tlast ? ST_PAD80 : ST_IDLE;
                            state_next = ST_KICK;
                        end
                        else if (s_tlast)
                        begin
                            state_next = ST_PAD80;
                        end
                    end
                    else if (s_tlast)
                    begin
                        state_next = ST_PAD80;
                    end
                end
            end
            ST_PAD80:
            begin
                buf_next = {buf_reg[503:0], PAD_BYTE};
                pos_next = pos_reg + 1'b1;
                if (pos_reg == LAST_POS)
                begin
                    ret_next   = ST_PADZ;
                    state_next = ST_KICK;
                end
                else
                begin
                    state_next = ST_PADZ;
                end
            end
            ST_PADZ:
            begin
                // Zero fill runs to the length field, through an extra block
                // when the pad byte landed past it.
                if (pos_reg == LEN_POS)
                begin
                    state_next = ST_LEN;
                end
                else
                begin
                    buf_next = {buf_reg[503:0], 8'h00};
                    pos_next = pos_reg + 1'b1;
                    if (pos_reg == LAST_POS)
                    begin
                        ret_next   = ST_PADZ;
                        state_next = ST_KICK;
                    end
                end
            end
            ST_LEN:
            begin
                buf_next   = {buf_reg[447:0], count_reg, 3'b000};
                pos_next   = '0;
                ret_next   = ST_FIN;
                state_next = ST_KICK;
            end
            ST_KICK:
            begin
                core_ctrl.start = 1'b1;
                state_next      = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (core_stat.done)
                begin
                    state_next = ret_reg;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_next          = {chain.g, chain.h, chain.e, chain.f,
                                         chain.c, chain.d, chain.a, chain.b};
                    out_valid_next    = 1'b1;
                    core_ctrl.iv_load = 1'b1;
                    count_next        = '0;
                    pos_next          = '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

`ifndef SYNTHESIS
    a_ready_core_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !core_stat.busy)
        else $error("input ready while a block is being compressed");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        core_stat.done |-> state_reg == ST_WAIT)
        else $error("compression finished outside the wait state");

    a_len_fills_block: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LEN |=> (pos_reg == '0 && state_reg == ST_KICK))
        else $error("length field did not complete the block");
`endif

endmodule

/* verif/tb_sm3_hash_engine.sv */
// Self-checking testbench for sm3_hash_engine: random byte messages go in,
// and each digest is compared against a bit-exact SM3 predictor kept here.
// Depends on sm3_pkg and the sm3_hash_engine RTL.
module tb_sm3_hash_engine;
    import sm3_pkg::*;

    localparam int WATCHDOG_LIMIT = 10000;
    localparam int OUT_HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = 250;
    localparam int ITEM_TARGET = 1500;
    localparam int MSG_TARGET = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       last;
        logic       drain;   // sender waits for all digests before this beat
    } byte_beat_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tuser = 1'b0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;

    byte_beat_t   pending_beats[$];
    logic [255:0] expected_digests[$];

    // Predictor state.
    logic [31:0]  chain_words[8];
    logic [31:0]  msg_words[16];
    logic [63:0]  msg_bytes;

    int           err_cnt = 0;
    int           digests_checked = 0;
    int           msg_total = 0;
    int           beat_total = 0;
    int           cycle_no = 0;
    int           quiet_cycles = 0;
    logic         out_hold_done = 1'b0;
    int           out_hold_left = 0;

    sm3_hash_engine i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
        int unsigned k;
        k = n % 32;
        return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
    endfunction

    function automatic logic [31:0] perm_p0(input logic [31:0] x);
        return x ^ rol32(x, 9) ^ rol32(x, 17);
    endfunction

    function automatic logic [31:0] perm_p1(input logic [31:0] x);
        return x ^ rol32(x, 15) ^ rol32(x, 23);
    endfunction

    task automatic load_iv();
        chain_words[0] = SM3_IV.a;
        chain_words[1] = SM3_IV.b;
        chain_words[2] = SM3_IV.c;
        chain_words[3] = SM3_IV.d;
        chain_words[4] = SM3_IV.e;
        chain_words[5] = SM3_IV.f;
        chain_words[6] = SM3_IV.g;
        chain_words[7] = SM3_IV.h;
        msg_bytes = '0;
    endtask

    task automatic put_msg_byte(input int unsigned pos, input logic [7:0] v);
        msg_words[(pos / 4) % 16][8 * (3 - pos % 4) +: 8] = v;
    endtask

    task automatic compress_msg_block();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, t;
        for (int j = 0; j < 16; j++) w[j] = msg_words[j];
        for (int j = 16; j < 68; j++)
        begin
            t = w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15);
            w[j] = perm_p1(t) ^ rol32(w[j-13], 7) ^ w[j-6];
        end
        a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
        e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
        for (int j = 0; j < 64; j++)
        begin
            tj  = (j < 16) ? T_LOW : T_HIGH;
            a12 = rol32(a, 12);
            ss1 = rol32(a12 + e + rol32(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ff = a ^ b ^ c;
                gg = e ^ f ^ g;
            end
            else
            begin
                ff = (a & b) | (a & c) | (b & c);
                gg = (e & f) | (~e & g);
            end
            tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = gg + h + ss1 + w[j];
            d = c; c = rol32(b, 9); b = a; a = tt1;
            h = g; g = rol32(f, 19); f = e; e = perm_p0(tt2);
        end
        chain_words[0] ^= a; chain_words[1] ^= b; chain_words[2] ^= c; chain_words[3] ^= d;
        chain_words[4] ^= e; chain_words[5] ^= f; chain_words[6] ^= g; chain_words[7] ^= h;
    endtask

    // Absorbs one accepted beat; a final beat pads, finishes and queues the digest.
    task automatic hash_beat(input logic [7:0] data, input logic has, input logic last);
        int unsigned pos;
        logic [63:0] nbits;
        logic [255:0] digest;
        if (has)
        begin
            pos = msg_bytes % BLOCK_BYTES;
            put_msg_byte(pos, data);
            msg_bytes++;
            if (pos == BLOCK_BYTES - 1) compress_msg_block();
        end
        if (last)
        begin
            nbits = msg_bytes << 3;
            pos = msg_bytes % BLOCK_BYTES;
            put_msg_byte(pos, PAD_BYTE);
            pos++;
            if (pos > int'(LEN_POS))
            begin
                while (pos < BLOCK_BYTES)
                begin
                    put_msg_byte(pos, 8'h00);
                    pos++;
                end
                compress_msg_block();
                pos = 0;
            end
            while (pos < int'(LEN_POS))
            begin
                put_msg_byte(pos, 8'h00);
                pos++;
            end
            msg_words[14] = nbits[63:32];
            msg_words[15] = nbits[31:0];
            compress_msg_block();
            digest = {chain_words[6], chain_words[7], chain_words[4], chain_words[5],
                      chain_words[2], chain_words[3], chain_words[0], chain_words[1]};
            expected_digests.insert(expected_digests.size(), digest);
            load_iv();
        end
    endtask

    task automatic add_beat(input logic [7:0] data, input logic has, input logic last,
                            input logic drain);
        byte_beat_t bt;
        bt.data  = data;
        bt.has   = has;
        bt.last  = last;
        bt.drain = drain;
        pending_beats.insert(pending_beats.size(), bt);
        if (has || last) beat_total++;
    endtask

    // Queues a message of len bytes; the end rides on the last byte or on an
    // empty final beat. Ignored beats are scattered in as noise.
    task automatic add_message(input int len, input logic empty_end, input logic drain);
        logic first;
        first = drain;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                add_beat(8'($urandom), 1'b0, 1'b0, first);
                first = 1'b0;
            end
            add_beat(8'($urandom), 1'b1, (i == len - 1) && !empty_end, first);
            first = 1'b0;
        end
        if (len == 0 || empty_end) add_beat(8'($urandom), 1'b0, 1'b1, first);
        msg_total++;
    endtask

    // Sender: presents queued beats, absorbs each accepted one into the predictor.
    always @(posedge clk)
    begin : drive_bytes
        byte_beat_t nxt;
        logic       offer;
        if (rst_n)
        begin
            if (s_tvalid && s_tready) hash_beat(s_tdata, s_tuser, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                offer = 1'b0;
                if (pending_beats.size() != 0)
                begin
                    offer = !(pending_beats[0].drain && expected_digests.size() != 0);
                    if (offer && (cycle_no < 3000 || cycle_no >= 8000))
                        offer = $urandom_range(99) >= 6;
                end
                if (offer)
                begin
                    nxt = pending_beats.pop_front();
                    s_tdata <= nxt.data;
                    s_tuser <= nxt.has;
                    s_tlast <= nxt.last;
                end
                s_tvalid <= offer;
            end
        end
    end

    // Receiver: checks every digest beat and drives m_tready with stalls.
    always @(posedge clk)
    begin : check_digests
        logic [255:0] exp_digest;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_digests.size() == 0)
                begin
                    $error("unexpected digest %h", m_tdata);
                    err_cnt++;
                end
                else
                begin
                    exp_digest = expected_digests.pop_front();
                    for (int k = 0; k < 4; k++)
                    begin
                        if (m_tdata[64*k +: 64] !== exp_digest[64*k +: 64])
                        begin
                            $error("digest_%0d mismatch: expected %h, actual %h", k,
                                   exp_digest[64*k +: 64], m_tdata[64*k +: 64]);
                            err_cnt++;
                        end
                    end
                    digests_checked++;
                end
            end
            // One long hold-off lets a second digest back up and stall the input.
            // It starts right after the drained message, while the sender keeps going.
            if (out_hold_left > 0)
            begin
                out_hold_left--;
                m_tready <= 1'b0;
            end
            else if (!out_hold_done && digests_checked == 6)
            begin
                out_hold_done = 1'b1;
                out_hold_left = OUT_HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else if (cycle_no >= 3000 && cycle_no < 8000)
                m_tready <= 1'b1;
            else
                m_tready <= $urandom_range(99) >= 6;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            cycle_no <= cycle_no + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no beat moved for %0d cycles.", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int          sel;
        int          len;
        int          edges[12];
        load_iv();
        msg_words = '{default: '0};
        edges = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

        // Directed: empty message, "abc", ignored beats around an empty end,
        // extreme byte values, end on a byte.
        add_beat(8'h00, 1'b0, 1'b1, 1'b0);
        add_beat(8'h61, 1'b1, 1'b0, 1'b0);
        add_beat(8'h62, 1'b1, 1'b0, 1'b0);
        add_beat(8'h63, 1'b1, 1'b1, 1'b0);
        add_beat(8'hFF, 1'b0, 1'b0, 1'b1);
        add_beat(8'hFF, 1'b1, 1'b0, 1'b0);
        add_beat(8'h00, 1'b0, 1'b0, 1'b0);
        add_beat(8'hFF, 1'b0, 1'b1, 1'b0);
        add_beat(8'h00, 1'b1, 1'b1, 1'b0);
        add_beat(8'hAA, 1'b1, 1'b0, 1'b0);
        add_beat(8'h55, 1'b1, 1'b1, 1'b0);
        msg_total += 5;

        // Random messages, weighted toward short ones and padding boundaries.
        // No random drains right after the first one, so the output hold-off
        // meets a sender that keeps offering beats.
        while (beat_total < ITEM_TARGET || msg_total < MSG_TARGET)
        begin
            sel = $urandom_range(99);
            if (sel < 60)
                len = $urandom_range(0, 20);
            else if (sel < 85)
                len = edges[$urandom_range(11)];
            else if (sel < 95)
                len = $urandom_range(21, 130);
            else
                len = $urandom_range(131, 260);
            add_message(len, $urandom_range(99) < 20,
                        (msg_total == 5) || (msg_total > 15 && $urandom_range(99) < 5));
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || s_tvalid || expected_digests.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Hashed %0d messages in %0d beats; %0d digests checked.",
                 msg_total, beat_total, digests_checked);
        $display("Run included padding boundaries, empty ends, a long output stall ",
                 "and drained pauses.");
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hdl/sm3_pkg.sv
hdl/sm3_round.sv
hdl/sm3_core.sv
hdl/sm3_hash_engine.sv
verif/tb_sm3_hash_engine.sv
